/* rtl/gfw_pkg.sv */
// ----------------------------------------------------------------------------
// gfw_pkg
// Shared constants for the Gaussian filter weight pipeline: exp tables,
// register indexes and fixed widths.
// ----------------------------------------------------------------------------
package gfw_pkg;

  localparam int MAG_W   = 17;  // |offset|, up to 32768
  localparam int SQ_W    = 31;  // mag^2, up to 2^30
  localparam int PROD_W  = 47;  // alpha * mag^2
  localparam int E_W     = 31;  // exp in Q30, up to 2^30
  localparam int EQ16_W  = 17;  // exp in Q16, up to 65536
  localparam int NFRAC   = 16;
  localparam int EV_STAGES = 20;  // sq, arg, init, 16 frac steps, round

  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_RADIUS_X = 2'd1;
  localparam logic [1:0] REG_RADIUS_Y = 2'd2;

  // exp(-k), Q30
  localparam logic [E_W-1:0] EXP_INT [16] = '{
    31'd1073741824, 31'd395007542, 31'd145315154, 31'd53458458,
    31'd19666267,   31'd7234816,   31'd2661540,   31'd979126,
    31'd360200,     31'd132510,    31'd48748,     31'd17933,
    31'd6597,       31'd2427,      31'd893,       31'd328
  };

  // exp(-2^-i) for i = 1..16, Q30
  localparam logic [29:0] EXP_FRAC [16] = '{
    30'd651257337,  30'd836230973,  30'd947573834,  30'd1008687096,
    30'd1040706261, 30'd1057095000, 30'd1065385899, 30'd1069555701,
    30'd1071646719, 30'd1072693760, 30'd1073217664, 30'd1073479712,
    30'd1073610760, 30'd1073676290, 30'd1073709056, 30'd1073725440
  };

endpackage

/* rtl/gfw_exp_pipe.sv */
// ----------------------------------------------------------------------------
// gfw_exp_pipe
// Computes exp(-alpha*mag^2) in Q16 over a 20-stage pipeline: square,
// scale, integer table lookup, one multiply per fraction bit, rounding.
// ----------------------------------------------------------------------------
module gfw_exp_pipe #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic [gfw_pkg::EV_STAGES-1:0]     en_i,
  input  logic [15:0]                       alpha_i,
  input  logic [gfw_pkg::MAG_W-1:0]         mag_i,
  output logic [gfw_pkg::EQ16_W-1:0]        exp_o
);
  import gfw_pkg::*;

  localparam int ARG_SHIFT = 3 * FRAC_BITS - 16;

  logic [2*MAG_W-1:0]  sq_full;
  logic [SQ_W-1:0]     sq_q;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   targ;
  logic                flush1_q;
  logic [3:0]          k1_q;
  logic [NFRAC-1:0]    frac1_q;

  logic [E_W-1:0]      e_q     [NFRAC+1];
  logic [NFRAC-1:0]    frac_q  [NFRAC+1];
  logic                flush_q [NFRAC+1];
  logic [EQ16_W-1:0]   exp_q;
  logic [E_W:0]        e_rnd;

  assign sq_full = mag_i * mag_i;
  assign prod    = PROD_W'(alpha_i) * PROD_W'(sq_q);
  assign targ    = prod >> ARG_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) sq_q <= sq_full[SQ_W-1:0];
    if (en_i[1]) begin
      flush1_q <= |targ[PROD_W-1:20];
      k1_q     <= targ[19:16];
      frac1_q  <= targ[15:0];
    end
    if (en_i[2]) begin
      e_q[0]     <= EXP_INT[k1_q];
      frac_q[0]  <= frac1_q;
      flush_q[0] <= flush1_q;
    end
  end

  // one multiply per fraction bit, most significant bit first
  for (genvar j = 0; j < NFRAC; j++) begin : g_frac
    logic [E_W+30-1:0] mul;
    assign mul = e_q[j] * EXP_FRAC[j];
    always_ff @(posedge clk_i) begin
      if (en_i[3+j]) begin
        e_q[j+1]     <= frac_q[j][NFRAC-1-j] ? mul[E_W+30-1:30] : e_q[j];
        frac_q[j+1]  <= frac_q[j];
        flush_q[j+1] <= flush_q[j];
      end
    end
  end

  assign e_rnd = {1'b0, e_q[NFRAC]} + (E_W+1)'(8192);

  always_ff @(posedge clk_i) begin
    if (en_i[EV_STAGES-1]) begin
      exp_q <= flush_q[NFRAC] ? '0 : e_rnd[30:14];
    end
  end

  assign exp_o = exp_q;

endmodule

/* rtl/gaussian_filter_weight.sv */
// ----------------------------------------------------------------------------
// gaussian_filter_weight
// Truncated Gaussian reconstruction filter weight g(x)*g(y), Q1.16.
// ----------------------------------------------------------------------------
// Takes one offset pair per cycle while in_stall_o is low and returns its
// weight after the 16 chained multiplies of the exp evaluation, one per
// stage, plus square, scale, lookup, round, difference and product stages.
// Four exp pipelines run side by side: two for the offsets, two for the
// radii. A stage holds its beat only while the next stage is full, so
// bubbles close up and the input keeps taking beats while a result waits.
// The user must write configuration only while the pipe is empty; not enforced.
// ----------------------------------------------------------------------------
module gaussian_filter_weight #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] weight_o
);
  import gfw_pkg::*;

  localparam int NST = EV_STAGES + 2;

  logic [15:0] alpha_q;
  logic [14:0] radius_x_q, radius_y_q;
  logic [NST-1:0] v_q, en;
  logic [MAG_W-1:0] mag_x, mag_y;
  logic [EQ16_W-1:0] ex, erx, ey, ery;
  logic [EQ16_W-1:0] gx_q, gy_q;
  logic [2*EQ16_W-1:0] wprod;
  logic [16:0] w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= '0;
      radius_x_q <= 15'd8192;
      radius_y_q <= 15'd8192;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALPHA:    alpha_q    <= cfg_wdata_i;
        REG_RADIUS_X: radius_x_q <= cfg_wdata_i[14:0];
        REG_RADIUS_Y: radius_y_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // stage k loads when empty or when the stage after it moves on
  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  // most negative offset gives 32768
  assign mag_x = offset_x_i[15] ? (MAG_W'(17'h10000) - {1'b0, offset_x_i})
                                : {1'b0, offset_x_i};
  assign mag_y = offset_y_i[15] ? (MAG_W'(17'h10000) - {1'b0, offset_y_i})
                                : {1'b0, offset_y_i};

  gfw_exp_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_x (
    .clk_i, .en_i(en[EV_STAGES-1:0]), .alpha_i(alpha_q), .mag_i(mag_x), .exp_o(ex));
  gfw_exp_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_rx (
    .clk_i, .en_i(en[EV_STAGES-1:0]), .alpha_i(alpha_q),
    .mag_i({2'b00, radius_x_q}), .exp_o(erx));
  gfw_exp_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_y (
    .clk_i, .en_i(en[EV_STAGES-1:0]), .alpha_i(alpha_q), .mag_i(mag_y), .exp_o(ey));
  gfw_exp_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_ry (
    .clk_i, .en_i(en[EV_STAGES-1:0]), .alpha_i(alpha_q),
    .mag_i({2'b00, radius_y_q}), .exp_o(ery));

  assign wprod = gx_q * gy_q;

  always_ff @(posedge clk_i) begin
    if (en[EV_STAGES]) begin
      gx_q <= (ex > erx) ? (ex - erx) : '0;
      gy_q <= (ey > ery) ? (ey - ery) : '0;
    end
    if (en[NST-1]) begin
      w_q <= 17'(({1'b0, wprod} + (2*EQ16_W+1)'(32768)) >> 16);
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign weight_o    = w_q;

endmodule

/* rtl/gfw_checker.sv */
// ----------------------------------------------------------------------------
// gfw_props
// Port-level checks for gaussian_filter_weight.
// ----------------------------------------------------------------------------
module gfw_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [16:0] weight_o
);

  // an empty output slot means the whole pipe can move
  a_no_stall_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("input stalled with empty output");

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o) else $error("input stalled while output drains");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weight_o <= 17'd65536)) else $error("weight above one");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weight_o))
    else $error("stalled output beat changed");

endmodule

bind gaussian_filter_weight gfw_props u_gfw_props (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .weight_o
);

/* dv/gfw_checker.sv */
// ----------------------------------------------------------------------------
// gfw_checker
// Watches the offset and weight channels of the Gaussian filter weight block,
// predicts each weight from the offsets and the current register settings,
// and compares every weight beat with the oldest prediction.
// ----------------------------------------------------------------------------
module gfw_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] offset_x_i,
  input  logic signed [15:0] offset_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [16:0]        weight_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfw_pkg::*;

  logic [15:0] alpha_q;
  logic [14:0] rad_x_q;
  logic [14:0] rad_y_q;
  logic [16:0] weight_q[$];

  // exp(-t), t in Q16; result Q16 rounded
  function automatic logic [63:0] exp_q16(logic [63:0] t);
    logic [63:0] e;
    if ((t >> 20) != 0) return 0;
    e = 64'(EXP_INT[t[19:16]]);
    for (int i = 1; i <= 16; i++) begin
      if (t[16-i]) e = (e * 64'(EXP_FRAC[i-1])) >> 30;
    end
    return (e + 64'd8192) >> 14;
  endfunction

  function automatic logic [63:0] exp_of_mag(logic [63:0] mag);
    return exp_q16((64'(alpha_q) * mag * mag) >> (3 * 12 - 16));
  endfunction

  function automatic logic [63:0] axis_gain(logic [15:0] d, logic [14:0] rad);
    logic [63:0] mag, ed, er;
    mag = d[15] ? (64'h10000 - 64'(d)) : 64'(d);
    ed  = exp_of_mag(mag);
    er  = exp_of_mag(64'(rad));
    return (ed > er) ? ed - er : 0;
  endfunction

  function automatic logic [16:0] filter_weight(logic [15:0] x, logic [15:0] y);
    logic [63:0] p;
    p = axis_gain(x, rad_x_q) * axis_gain(y, rad_y_q);
    return 17'((p + 64'd32768) >> 16);
  endfunction

  assign pending_o = weight_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= '0;
      rad_x_q    <= 15'd8192;
      rad_y_q    <= 15'd8192;
      fail_cnt_o <= 0;
      weight_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA:    alpha_q <= cfg_wdata_i;
          REG_RADIUS_X: rad_x_q <= cfg_wdata_i[14:0];
          REG_RADIUS_Y: rad_y_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) weight_q.push_back(filter_weight(offset_x_i, offset_y_i));
      if (out_valid_i && !out_stall_i) begin
        if (weight_q.size() == 0) begin
          $error("weight: unexpected beat, actual %0d", weight_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          logic [16:0] exp_w;
          exp_w = weight_q.pop_front();
          if (exp_w !== weight_i) begin
            $error("weight: expected %0d actual %0d", exp_w, weight_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_gaussian_filter_weight.sv */
// ----------------------------------------------------------------------------
// tb_gaussian_filter_weight
// Drives directed and random offset pairs under several register settings,
// with random gaps and output stalls; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb_gaussian_filter_weight;
  timeunit 1ns;
  timeprecision 1ps;
  import gfw_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] off_x = '0;
  logic signed [15:0] off_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [16:0]        weight;
  int                 fail_cnt;
  int                 pending;
  int                 idle_pct = 28;
  int                 quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gaussian_filter_weight dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .offset_x_i(off_x), .offset_y_i(off_y), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .weight_o(weight)
  );

  gfw_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .offset_x_i(off_x), .offset_y_i(off_y), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .weight_i(weight), .fail_cnt_o(fail_cnt),
    .pending_o(pending)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < idle_pct);

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // leaves in_valid high after the beat; drain, or a random gap in the next send, lowers it
  task automatic send(logic [15:0] x, logic [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    off_x <= x;
    off_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] a, logic [14:0] rx, logic [14:0] ry);
    write_reg(REG_ALPHA, a);
    write_reg(REG_RADIUS_X, {1'b0, rx});
    write_reg(REG_RADIUS_Y, {1'b0, ry});
    cfg_we <= 1'b0;
  endtask

  // offsets mostly inside the radius, sometimes anywhere
  function automatic logic [15:0] rand_offset(int rad);
    int m;
    if ($urandom_range(3) == 0) return 16'($urandom);
    m = $urandom_range(rad + 256);
    return ($urandom_range(1) != 0) ? 16'(-m) : 16'(m);
  endfunction

  initial begin
    logic [15:0] a;
    int rx, ry;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: alpha zero gives zero weight
    send(16'h0000, 16'h0000);
    send(16'h1000, 16'hF000);
    drain();

    set_regs(16'h2000, 15'd8192, 15'd8192);
    send(16'h0000, 16'h0000);
    send(16'h7FFF, 16'h0000);
    send(16'h8000, 16'h8000);
    send(16'h8001, 16'h0800);
    send(16'h2000, 16'hE000);
    send(16'h2001, 16'h0000);
    send(16'h0400, 16'hFC00);
    drain();
    // exp argument beyond the table, and full-scale settings
    set_regs(16'hFFFF, 15'h7FFF, 15'h7FFF);
    send(16'h0000, 16'h0000);
    send(16'h0100, 16'hFF00);
    send(16'h8000, 16'h7FFF);
    send(16'h1000, 16'h0000);
    drain();
    set_regs(16'h0001, 15'h7FFF, 15'd0);
    send(16'h0000, 16'h0000);
    send(16'h7FFF, 16'h0000);
    send(16'h5555, 16'hAAAA);
    drain();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    cfg_we <= 1'b0;
    send(16'h0001, 16'h0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      a  = (ph == 7) ? 16'($urandom) : 16'($urandom_range(16'h6000, 16'h0400));
      rx = (ph == 6) ? 32767 : $urandom_range(16384, 1024);
      ry = (ph == 5) ? 0 : $urandom_range(16384, 1024);
      idle_pct = (ph == 3) ? 0 : 28;
      set_regs(a, 15'(rx), 15'(ry));
      for (int n = 0; n < 235; n++) send(rand_offset(rx), rand_offset(ry));
      drain();
    end
    idle_pct = 28;

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/gfw_pkg.sv
rtl/gfw_exp_pipe.sv
rtl/gaussian_filter_weight.sv
rtl/gfw_checker.sv
dv/gfw_checker.sv
dv/tb_gaussian_filter_weight.sv
